>>> design/vqt_pkg.sv
package vqt_pkg;

    localparam int unsigned MAX_RING_SIZE = 32768;
    localparam int unsigned IDX_W         = 16;
    localparam int unsigned SLOT_W        = 15;
    localparam int unsigned ADDR_W        = 4;
    localparam int unsigned DATA_W        = 32;

    typedef enum logic [2:0] {
        ACT_TAKE_AVAIL    = 3'd0,
        ACT_ADD_USED      = 3'd1,
        ACT_CHECK_NOTIFY  = 3'd2,
        ACT_ENABLE_NOTIFY = 3'd3,
        ACT_DISABLE_NOTIFY = 3'd4,
        ACT_DISCARD       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    localparam logic [1:0] REG_RING_SIZE       = 2'd0;
    localparam logic [1:0] REG_EVENT_IDX_ON    = 2'd1;
    localparam logic [1:0] REG_NOTIFY_ON_EMPTY = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] ring_size;
        logic             event_idx_on;
        logic             notify_on_empty;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [IDX_W-1:0] guest_avail_idx;
        logic             guest_no_interrupt;
        logic [IDX_W-1:0] guest_used_event;
        logic [IDX_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] ring_slot;
        logic [IDX_W-1:0]  pending_count;
        logic              need_irq;
        logic              more_pending;
        logic [IDX_W-1:0]  used_idx_out;
        logic              used_flags_write;
        logic              no_notify_value;
        logic              avail_event_write;
        logic [IDX_W-1:0]  avail_event_value;
    } result_t;

endpackage

>>> design/vqt_cfg_regs.sv
module vqt_cfg_regs
    import vqt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RING_SIZE:       cfg_next.ring_size       = pwdata[IDX_W-1:0];
                REG_EVENT_IDX_ON:    cfg_next.event_idx_on    = pwdata[0];
                REG_NOTIFY_ON_EMPTY: cfg_next.notify_on_empty = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RING_SIZE:       prdata = {{(DATA_W-IDX_W){1'b0}}, cfg_reg.ring_size};
            REG_EVENT_IDX_ON:    prdata = {{(DATA_W-1){1'b0}}, cfg_reg.event_idx_on};
            REG_NOTIFY_ON_EMPTY: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.notify_on_empty};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_size       <= IDX_W'(256);
            cfg_reg.event_idx_on    <= 1'b0;
            cfg_reg.notify_on_empty <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/vqt_core.sv
module vqt_core
    import vqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    item_t             item_reg;
    logic              item_valid_reg;
    logic              advance;

    logic [IDX_W-1:0]  next_avail_reg,      next_avail_next;
    logic [IDX_W-1:0]  avail_snapshot_reg,  avail_snapshot_next;
    logic [IDX_W-1:0]  next_used_reg,       next_used_next;
    logic [IDX_W-1:0]  signalled_idx_reg,   signalled_idx_next;
    logic              signalled_known_reg, signalled_known_next;
    logic              suppressed_reg,      suppressed_next;

    logic [IDX_W-1:0]  eff_size;
    logic [IDX_W-1:0]  size_m1;
    logic [SLOT_W-1:0] slot_mask;
    logic [IDX_W-1:0]  avail_count;
    logic [IDX_W-1:0]  used_new;
    logic [IDX_W-1:0]  event_dist;
    logic [IDX_W-1:0]  signal_dist;

    assign advance   = item_valid_reg & res_ready;
    assign in_ready  = ~item_valid_reg | res_ready;
    assign res_valid = item_valid_reg;

    // ring sizes beyond the limit clamp; a zero size masks with all ones
    assign eff_size  = (cfg.ring_size > IDX_W'(MAX_RING_SIZE)) ? IDX_W'(MAX_RING_SIZE)
                                                                : cfg.ring_size;
    assign size_m1   = eff_size - IDX_W'(1);
    assign slot_mask = size_m1[SLOT_W-1:0];

    assign avail_count = item_reg.guest_avail_idx - next_avail_reg;
    assign used_new    = next_used_reg + item_reg.amount;
    assign event_dist  = next_used_reg - item_reg.guest_used_event - IDX_W'(1);
    assign signal_dist = next_used_reg - signalled_idx_reg;

    always_comb
    begin
        next_avail_next      = next_avail_reg;
        avail_snapshot_next  = avail_snapshot_reg;
        next_used_next       = next_used_reg;
        signalled_idx_next   = signalled_idx_reg;
        signalled_known_next = signalled_known_reg;
        suppressed_next      = suppressed_reg;
        res                  = '0;
        res.status           = ST_OK;

        case (item_reg.action)
            ACT_TAKE_AVAIL:
            begin
                avail_snapshot_next = item_reg.guest_avail_idx;
                if (avail_count == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else if (avail_count > eff_size)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.ring_slot   = next_avail_reg[SLOT_W-1:0] & slot_mask;
                    next_avail_next = next_avail_reg + IDX_W'(1);
                end
            end
            ACT_ADD_USED:
            begin
                if (item_reg.amount > eff_size)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.ring_slot  = next_used_reg[SLOT_W-1:0] & slot_mask;
                    next_used_next = used_new;
                    // last signalled index falls inside the published window
                    if ((used_new - signalled_idx_reg) < item_reg.amount)
                    begin
                        signalled_known_next = 1'b0;
                    end
                end
            end
            ACT_CHECK_NOTIFY:
            begin
                if (cfg.notify_on_empty && (avail_snapshot_reg == next_avail_reg))
                begin
                    res.need_irq = 1'b1;
                end
                else if (!cfg.event_idx_on)
                begin
                    res.need_irq = ~item_reg.guest_no_interrupt;
                end
                else
                begin
                    signalled_idx_next   = next_used_reg;
                    signalled_known_next = 1'b1;
                    res.need_irq = ~signalled_known_reg | (event_dist < signal_dist);
                end
            end
            ACT_ENABLE_NOTIFY:
            begin
                if (suppressed_reg)
                begin
                    suppressed_next = 1'b0;
                    if (!cfg.event_idx_on)
                    begin
                        res.used_flags_write = 1'b1;
                    end
                    else
                    begin
                        res.avail_event_write = 1'b1;
                        res.avail_event_value = avail_snapshot_reg;
                    end
                    res.more_pending = (item_reg.guest_avail_idx != avail_snapshot_reg);
                end
            end
            ACT_DISABLE_NOTIFY:
            begin
                if (!suppressed_reg)
                begin
                    suppressed_next      = 1'b1;
                    res.used_flags_write = ~cfg.event_idx_on;
                end
            end
            ACT_DISCARD:
            begin
                next_avail_next = next_avail_reg - item_reg.amount;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase

        res.pending_count   = avail_snapshot_next - next_avail_next;
        res.used_idx_out    = next_used_next;
        res.no_notify_value = suppressed_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg      <= 1'b0;
            next_avail_reg      <= '0;
            avail_snapshot_reg  <= '0;
            next_used_reg       <= '0;
            signalled_idx_reg   <= '0;
            signalled_known_reg <= 1'b0;
            suppressed_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                next_avail_reg      <= next_avail_next;
                avail_snapshot_reg  <= avail_snapshot_next;
                next_used_reg       <= next_used_next;
                signalled_idx_reg   <= signalled_idx_next;
                signalled_known_reg <= signalled_known_next;
                suppressed_reg      <= suppressed_next;
            end
        end
    end

endmodule

>>> design/vqt_result_reg.sv
module vqt_result_reg
    import vqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

endmodule

>>> design/virtqueue_index_and_notify_tracker.sv
// a result is shown once its transaction has passed the input register
// and then the result register
// throughput: one transaction per cycle unless out_ready stalls; all index
// math is 16-bit add/compare between the two registers
// reset: asynchronous, rst_n low clears all ring indices and flags,
// ring_size returns to 256 and both feature bits to 0
module virtqueue_index_and_notify_tracker
    import vqt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [IDX_W-1:0]  guest_avail_idx,
    input  logic              guest_no_interrupt,
    input  logic [IDX_W-1:0]  guest_used_event,
    input  logic [IDX_W-1:0]  amount,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] ring_slot,
    output logic [IDX_W-1:0]  pending_count,
    output logic              need_irq,
    output logic              more_pending,
    output logic [IDX_W-1:0]  used_idx_out,
    output logic              used_flags_write,
    output logic              no_notify_value,
    output logic              avail_event_write,
    output logic [IDX_W-1:0]  avail_event_value
);

    cfg_t    cfg;
    item_t   in_item;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    res_ready;

    assign in_item.action             = action;
    assign in_item.guest_avail_idx    = guest_avail_idx;
    assign in_item.guest_no_interrupt = guest_no_interrupt;
    assign in_item.guest_used_event   = guest_used_event;
    assign in_item.amount             = amount;

    vqt_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vqt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    vqt_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status            = out_res.status;
    assign ring_slot         = out_res.ring_slot;
    assign pending_count     = out_res.pending_count;
    assign need_irq          = out_res.need_irq;
    assign more_pending      = out_res.more_pending;
    assign used_idx_out      = out_res.used_idx_out;
    assign used_flags_write  = out_res.used_flags_write;
    assign no_notify_value   = out_res.no_notify_value;
    assign avail_event_write = out_res.avail_event_write;
    assign avail_event_value = out_res.avail_event_value;

endmodule

>>> design/vqt_checker.sv
module vqt_checker
    import vqt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        status,
    input logic [SLOT_W-1:0] ring_slot,
    input logic              need_irq,
    input logic              more_pending,
    input logic              used_flags_write,
    input logic              no_notify_value,
    input logic              avail_event_write,
    input logic [IDX_W-1:0]  avail_event_value
);

    // a failed take or add never reports a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> ring_slot == '0)
        else $error("slot reported on failed transaction");

    // an interrupt decision comes only from check notify
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && need_irq |-> !used_flags_write && !avail_event_write && !more_pending)
        else $error("interrupt mixed with notify control");

    // avail event is written only on enable, which leaves notifications on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && avail_event_write |-> !used_flags_write && !no_notify_value)
        else $error("avail event write with suppression");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !avail_event_write |-> avail_event_value == '0)
        else $error("avail event value without strobe");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(ring_slot))
        else $error("stalled result changed");

endmodule

bind virtqueue_index_and_notify_tracker vqt_checker u_vqt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .ring_slot         (ring_slot),
    .need_irq          (need_irq),
    .more_pending      (more_pending),
    .used_flags_write  (used_flags_write),
    .no_notify_value   (no_notify_value),
    .avail_event_write (avail_event_write),
    .avail_event_value (avail_event_value)
);
